// ===== rtl/gcd_pkg.sv =====
// Shared constants and the arctangent table for the great-circle distance unit.
`default_nettype none
package gcd_pkg;
	localparam int TRIG_ITERATIONS = 32;
	localparam int SQRT_STEPS      = 31;

	localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;
	localparam logic [32:0]        DEG_TO_RAD   = 33'd8048910509;
	localparam logic signed [33:0] GAIN_INV     = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE      = 34'sd1073741824;
	localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
	localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
	localparam logic [29:0]        RADIUS_CM_RST = 30'd637100000;

	localparam int SC_LATENCY  = 4 + TRIG_ITERATIONS + 1;
	localparam int AC_LATENCY  = 1 + SQRT_STEPS + 1 + TRIG_ITERATIONS + 1;
	localparam int TOP_LATENCY = SC_LATENCY + 5 + AC_LATENCY + 2;

	// Truncated Q30 arctangent of 2^-i.
	function automatic logic [29:0] atan_q30(input int unsigned i);
		logic [30:0] p;
		p = '0;
		case (i)
			0: p = 31'h3243F6A8;
			1: p = 31'h1DAC6705;
			2: p = 31'h0FADBAFC;
			3: p = 31'h07F56EA6;
			4: p = 31'h03FEAB76;
			5: p = 31'h01FFD55B;
			6: p = 31'h00FFFAAA;
			7: p = 31'h007FFF55;
			8: p = 31'h003FFFEA;
			9: p = 31'h001FFFFD;
			default: begin
				if (i < 30) p = (31'd1 << (30 - i)) - 31'd1;
				else p = '0;
			end
		endcase
		return p[29:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/gcd_sincos.sv =====
// Pipelined sine/cosine of an angle in 1e-7 degree, rotation CORDIC one step per stage.
`default_nettype none
module gcd_sincos (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic signed [32:0] ang,
	output logic                    out_vld,
	output logic signed [31:0]      sin_v,
	output logic signed [31:0]      cos_v
);
	localparam int N = gcd_pkg::TRIG_ITERATIONS;

	logic signed [33:0] u, w;
	logic signed [32:0] f2;
	logic               neg2;
	logic [63:0]        rnd4;
	logic signed [33:0] z4;

	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [31:0] wr_s1;
	logic               neg_s2, sgn_s2, neg_s3, sgn_s3, neg_s4;
	logic [29:0]        mag_s2;
	logic [62:0]        prod_s3;
	logic signed [33:0] z_s4;

	logic               cv_s [0:N];
	logic               cn_s [0:N];
	logic signed [33:0] cx_s [0:N];
	logic signed [33:0] cy_s [0:N];
	logic signed [33:0] cz_s [0:N];

	// wrap into one turn, then fold to [-90, 90] degrees
	always_comb begin
		u = {ang[32], ang};
		if (u >= gcd_pkg::HALF_TURN) w = u - gcd_pkg::FULL_TURN;
		else if (u < -gcd_pkg::HALF_TURN) w = u + gcd_pkg::FULL_TURN;
		else w = u;
		neg2 = 1'b0;
		f2 = {wr_s1[31], wr_s1};
		if (34'(f2) > gcd_pkg::QUARTER_TURN) begin
			f2 = 33'(34'(f2) - gcd_pkg::HALF_TURN);
			neg2 = 1'b1;
		end else if (34'(f2) < -gcd_pkg::QUARTER_TURN) begin
			f2 = 33'(34'(f2) + gcd_pkg::HALF_TURN);
			neg2 = 1'b1;
		end
		rnd4 = {1'b0, prod_s3} + 64'h8000_0000;
		z4 = sgn_s3 ? -34'(rnd4[63:32]) : 34'(rnd4[63:32]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			out_vld <= cv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		wr_s1   <= w[31:0];
		neg_s2  <= neg2;
		sgn_s2  <= f2[32];
		mag_s2  <= f2[32] ? 30'(-f2) : f2[29:0];
		prod_s3 <= 63'(mag_s2) * 63'(gcd_pkg::DEG_TO_RAD);
		neg_s3  <= neg_s2;
		sgn_s3  <= sgn_s2;
		z_s4    <= z4;
		neg_s4  <= neg_s3;
		sin_v   <= cn_s[N] ? 32'(-cy_s[N]) : cy_s[N][31:0];
		cos_v   <= cn_s[N] ? 32'(-cx_s[N]) : cx_s[N][31:0];
	end

	assign cv_s[0] = vld_s4;
	assign cn_s[0] = neg_s4;
	assign cx_s[0] = gcd_pkg::GAIN_INV;
	assign cy_s[0] = '0;
	assign cz_s[0] = z_s4;

	for (genvar i = 0; i < N; i++) begin : g_rot
		localparam logic signed [33:0] AT = 34'(gcd_pkg::atan_q30(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[i+1] <= 1'b0;
			else cv_s[i+1] <= cv_s[i];
		end
		always_ff @(posedge clk) begin
			cn_s[i+1] <= cn_s[i];
			if (!cz_s[i][33]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - AT;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + AT;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gcd_acos.sv =====
// Pipelined Q30 arccos: floor square root one digit per stage, then vectoring CORDIC.
`default_nettype none
module gcd_acos (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic signed [31:0] c,
	output logic                    out_vld,
	output logic [31:0]             ang
);
	localparam int N = gcd_pkg::TRIG_ITERATIONS;
	localparam int S = gcd_pkg::SQRT_STEPS;

	logic               sv_s [0:S];
	logic signed [31:0] sc_s [0:S];
	logic [60:0]        sr_s [0:S];
	logic [61:0]        sq_s [0:S];

	logic               vv_s [0:N];
	logic signed [33:0] vx_s [0:N];
	logic signed [33:0] vy_s [0:N];
	logic signed [33:0] vz_s [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s[0] <= 1'b0;
			vv_s[0] <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			sv_s[0] <= in_vld;
			vv_s[0] <= sv_s[S];
			out_vld <= vv_s[N];
		end
	end

	// remainder 1 - c^2 in Q60, then setup of the vector, then clamp to [0, pi]
	always_ff @(posedge clk) begin
		sc_s[0] <= c;
		sr_s[0] <= 61'(62'h1000_0000_0000_0000 - 62'(c * c));
		sq_s[0] <= '0;
		if (sc_s[S][31]) begin
			vx_s[0] <= 34'(sq_s[S]);
			vy_s[0] <= -34'(sc_s[S]);
			vz_s[0] <= gcd_pkg::Q30_HALF_PI;
		end else begin
			vx_s[0] <= 34'(sc_s[S]);
			vy_s[0] <= 34'(sq_s[S]);
			vz_s[0] <= '0;
		end
		if (vz_s[N][33]) ang <= '0;
		else if (vz_s[N] > gcd_pkg::Q30_PI) ang <= gcd_pkg::Q30_PI[31:0];
		else ang <= vz_s[N][31:0];
	end

	for (genvar j = 0; j < S; j++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv_s[j+1] <= 1'b0;
			else sv_s[j+1] <= sv_s[j];
		end
		always_ff @(posedge clk) begin
			sc_s[j+1] <= sc_s[j];
			if (62'(sr_s[j]) >= sq_s[j] + BIT) begin
				sr_s[j+1] <= 61'(62'(sr_s[j]) - sq_s[j] - BIT);
				sq_s[j+1] <= (sq_s[j] >> 1) + BIT;
			end else begin
				sr_s[j+1] <= sr_s[j];
				sq_s[j+1] <= sq_s[j] >> 1;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		localparam logic signed [33:0] AT = 34'(gcd_pkg::atan_q30(i));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vv_s[i+1] <= 1'b0;
			else vv_s[i+1] <= vv_s[i];
		end
		always_ff @(posedge clk) begin
			if (vy_s[i] > 0) begin
				vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] + AT;
			end else begin
				vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
				vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
				vz_s[i+1] <= vz_s[i] - AT;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/great_circle_distance_unit.sv =====
// Top level of the great-circle distance unit (spherical law of cosines).
//
// Usage: drive lat_a, lon_a, lat_b, lon_b (1e-7 degree, signed) and pulse start.
// An item is taken at every rising edge with start high and busy low; busy stays
// low, so a new pair of positions may enter in every cycle.
// Each item gives one beat on done/distance_cm. It passes the three rotation
// CORDIC chains (one step per stage), the 31-stage square root and the
// vectoring CORDIC chain that forms the arccos; throughput is one item a cycle.
// Results leave in input order and done is high for one cycle per beat; the
// receiver must take every beat, it cannot hold them off.
// The radius register is written with cfg_we/cfg_wdata (metres) and is held
// internally already scaled to centimetres; write it only while no item is in
// flight. Reset (arst_n low) empties the pipeline, clears done and restores
// the radius to 6371000 m.
`default_nettype none
module great_circle_distance_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [30:0] lat_a,
	input  wire logic signed [31:0] lon_a,
	input  wire logic signed [30:0] lat_b,
	input  wire logic signed [31:0] lon_b,
	input  wire logic               cfg_we,
	input  wire logic [22:0]        cfg_wdata,
	output logic                    done,
	output logic [30:0]             distance_cm
);
	logic               acc;
	logic signed [32:0] dlon;
	logic               sc_vld, sc_vld_b, sc_vld_d, ac_vld;
	logic signed [31:0] sa, ca, sb, cb, sd, cd;
	logic [29:0]        rad_cm_q;
	logic signed [63:0] trnd, srnd;
	logic signed [33:0] cw;
	logic signed [31:0] cclamp;
	logic [31:0]        ang;
	logic [62:0]        drnd;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [63:0] ss_s1, ss_s2, ss_s3, tc_s3, sum_s4, cc_s1;
	logic signed [31:0] cd_s1, cd_s2, t_s2, c_s5;
	logic [61:0]        prod_s6;

	// no backpressure anywhere: every cycle can take a beat
	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign dlon = {lon_b[31], lon_b} - {lon_a[31], lon_a};

	// three sine/cosine chains run side by side with equal latency
	gcd_sincos u_sc_a (.clk, .arst_n, .in_vld(acc), .ang(33'(lat_a)),
		.out_vld(sc_vld), .sin_v(sa), .cos_v(ca));
	gcd_sincos u_sc_b (.clk, .arst_n, .in_vld(acc), .ang(33'(lat_b)),
		.out_vld(sc_vld_b), .sin_v(sb), .cos_v(cb));
	gcd_sincos u_sc_d (.clk, .arst_n, .in_vld(acc), .ang(dlon),
		.out_vld(sc_vld_d), .sin_v(sd), .cos_v(cd));

	always_comb begin
		// round cos(latA)cos(latB) to Q30 before it meets cos(dlon)
		trnd = (cc_s1 + 64'sd536870912) >>> 30;
		srnd = (sum_s4 + 64'sd536870912) >>> 30;
		cw = 34'(srnd);
		if (cw > gcd_pkg::Q30_ONE) cclamp = gcd_pkg::Q30_ONE[31:0];
		else if (cw < -gcd_pkg::Q30_ONE) cclamp = 32'(-gcd_pkg::Q30_ONE);
		else cclamp = cw[31:0];
		drnd = 63'(prod_s6) + 63'd536870912;
	end

	// radius held pre-scaled to centimetres
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rad_cm_q <= gcd_pkg::RADIUS_CM_RST;
		else if (cfg_we) rad_cm_q <= 30'(30'(cfg_wdata) * 30'd100);
	end

	// valid bits advance every cycle beside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= sc_vld & sc_vld_b & sc_vld_d;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= ac_vld;
			done   <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		ss_s1  <= 64'(sa) * 64'(sb);
		cc_s1  <= 64'(ca) * 64'(cb);
		cd_s1  <= cd;
		t_s2   <= trnd[31:0];
		ss_s2  <= ss_s1;
		cd_s2  <= cd_s1;
		tc_s3  <= 64'(t_s2) * 64'(cd_s2);
		ss_s3  <= ss_s2;
		sum_s4 <= ss_s3 + tc_s3;
		c_s5   <= cclamp;
		prod_s6 <= 62'(rad_cm_q) * 62'(ang);
		// saturate; only reachable with a radius outside the usual range
		if (drnd[62:30] > 33'h7FFF_FFFF) distance_cm <= 31'h7FFF_FFFF;
		else distance_cm <= drnd[60:30];
	end

	gcd_acos u_acos (.clk, .arst_n, .in_vld(vld_s5), .c(c_s5),
		.out_vld(ac_vld), .ang(ang));

	// sine of the longitude difference is not needed
	logic unused_sd;
	assign unused_sd = ^sd;
endmodule
`default_nettype wire

// ===== rtl/gcd_checker.sv =====
// Port-level assertions for the great-circle distance unit, bound to the top level.
`default_nettype none
module gcd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [30:0] distance_cm
);
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_rst_quiet: assert property (@(posedge clk) !arst_n |=> !done)
		else $error("result beat right after reset");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, gcd_pkg::TOP_LATENCY))
		else $error("result beat without a matching start");

	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, gcd_pkg::TOP_LATENCY) && $past(arst_n, gcd_pkg::TOP_LATENCY) &&
		$past(!busy, gcd_pkg::TOP_LATENCY) |-> done)
		else $error("start lost");

	logic unused_d;
	assign unused_d = ^distance_cm;
endmodule

bind great_circle_distance_unit gcd_checker u_gcd_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.done(done), .distance_cm(distance_cm)
);
`default_nettype wire

// ===== bench/great_circle_distance_checker.sv =====
// Distance predictor and result checker for the great-circle distance unit.
`timescale 1ns / 1ps
module great_circle_distance_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [30:0] lat_a,
	input  logic signed [31:0] lon_a,
	input  logic signed [30:0] lat_b,
	input  logic signed [31:0] lon_b,
	input  logic               cfg_we,
	input  logic [22:0]        cfg_wdata,
	input  logic               done,
	input  logic [30:0]        distance_cm,
	output int                 errors,
	output int                 pending,
	output int                 beats_in,
	output int                 beats_out
);
	localparam int STEPS = 32;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint GAIN_COMP = 64'sd652032874;
	localparam longint TURN = 64'sd3600000000;
	localparam longint HALF = 64'sd1800000000;
	localparam longint QUARTER = 64'sd900000000;
	localparam longint unsigned RAD_SCALE = 64'd8048910509;

	logic [22:0] radius_m;
	logic [30:0] distance_q[$];

	function automatic longint arctan_step(int i);
		longint head[10];
		head = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
			64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD};
		if (i < 10) return head[i];
		if (i >= 30) return 0;
		return (64'sd1 <<< (30 - i)) - 1;
	endfunction

	// Rotate by an angle in 1e-7 degree; fold into +/-90 degrees first.
	function automatic void rotate_angle(input longint turn, output longint s,
			output longint c);
		longint r, mag, z, x, y, dx, dy;
		bit flip;
		flip = 0;
		r = turn % TURN;
		if (r < 0) r += TURN;
		if (r >= HALF) r -= TURN;
		if (r > QUARTER) begin
			r -= HALF;
			flip = 1;
		end else if (r < -QUARTER) begin
			r += HALF;
			flip = 1;
		end
		mag = r < 0 ? -r : r;
		z = longint'((longint'(unsigned'(mag)) * RAD_SCALE + 64'd2147483648) >> 32);
		if (r < 0) z = -z;
		x = GAIN_COMP;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_step(i);
			end else begin
				x += dx; y -= dy; z += arctan_step(i);
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint floor_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else res >>= 1;
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint central_angle(longint c);
		longint y, vx, vy, z, dx, dy;
		y = floor_root(longint'(ONE_Q30 * ONE_Q30 - c * c));
		if (c < 0) begin
			vx = y; vy = -c; z = HALF_PI_Q30;
		end else begin
			vx = c; vy = y; z = 0;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy > 0) begin
				vx += dx; vy -= dy; z += arctan_step(i);
			end else begin
				vx -= dx; vy += dy; z -= arctan_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > PI_Q30) z = PI_Q30;
		return z;
	endfunction

	function automatic logic [30:0] predict_distance(longint la, longint oa, longint lb,
			longint ob, logic [22:0] rad);
		longint sa, ca, sb, cb, sd, cd, t, c, ang;
		logic [63:0] d;
		rotate_angle(la, sa, ca);
		rotate_angle(lb, sb, cb);
		rotate_angle(ob - oa, sd, cd);
		t = (ca * cb + (64'sd1 <<< 29)) >>> 30;
		c = (sa * sb + t * cd + (64'sd1 <<< 29)) >>> 30;
		if (c > ONE_Q30) c = ONE_Q30;
		if (c < -ONE_Q30) c = -ONE_Q30;
		ang = central_angle(c);
		d = (64'(rad) * 64'd100 * 64'(ang) + (64'd1 << 29)) >> 30;
		if (d > 64'h7FFFFFFF) d = 64'h7FFFFFFF;
		return d[30:0];
	endfunction

	assign pending = distance_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_m = 23'd6371000;
			errors = 0;
			beats_in = 0;
			beats_out = 0;
			distance_q.delete();
		end else begin
			if (done) begin
				beats_out++;
				if (distance_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected distance beat %0d", $time, distance_cm);
				end else begin
					if (distance_q[0] !== distance_cm) begin
						errors++;
						$display("%0t: distance_cm expected %0d actual %0d", $time,
							distance_q[0], distance_cm);
					end
					void'(distance_q.pop_front());
				end
			end
			if (start && !busy) begin
				beats_in++;
				distance_q.push_back(predict_distance(lat_a, lon_a, lat_b, lon_b, radius_m));
			end
			if (cfg_we) radius_m = cfg_wdata;
		end
	end
endmodule

// ===== bench/great_circle_distance_unit_test.sv =====
// Stimulus and verdict for the great-circle distance unit.
`timescale 1ns / 1ps
module great_circle_distance_unit_test;
	localparam int STALL_LIMIT = 4 * gcd_pkg::TOP_LATENCY + 200;
	localparam int RANDOM_PER_PHASE = 55;

	logic clk, arst_n, start, busy, cfg_we, done;
	logic signed [30:0] lat_a, lat_b;
	logic signed [31:0] lon_a, lon_b;
	logic [22:0] cfg_wdata;
	logic [30:0] distance_cm;
	int errors, pending, beats_in, beats_out;
	int idle_cycles;
	bit no_gaps;

	great_circle_distance_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .distance_cm(distance_cm)
	);

	great_circle_distance_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .distance_cm(distance_cm),
		.errors(errors), .pending(pending), .beats_in(beats_in), .beats_out(beats_out)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog: count cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// Present one position pair and hold it until the block takes the beat.
	task automatic send_pair(logic signed [30:0] la, logic signed [31:0] oa,
			logic signed [30:0] lb, logic signed [31:0] ob);
		int gap;
		bit taken;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			start <= 1'b1;
			lat_a <= la; lon_a <= oa; lat_b <= lb; lon_b <= ob;
			taken = !busy;
			@(posedge clk);
		end
	endtask

	// Drain every expected result, then write the radius while idle.
	task automatic set_radius(logic [22:0] r);
		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (gcd_pkg::TOP_LATENCY + 5) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_pair();
		logic signed [30:0] la, lb;
		logic signed [31:0] oa, ob;
		if ($urandom_range(0, 3) == 0) begin
			// raw bits, beyond-range angles included
			la = $urandom; lb = $urandom; oa = $urandom; ob = $urandom;
		end else begin
			la = $signed($urandom_range(0, 1800000000)) - 900000000;
			lb = $signed($urandom_range(0, 1800000000)) - 900000000;
			oa = longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
			if ($urandom_range(0, 3) == 0)
				ob = oa + $signed($urandom_range(0, 2000)) - 1000;
			else
				ob = longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
			if ($urandom_range(0, 7) == 0) lb = la;
		end
		send_pair(la, oa, lb, ob);
	endtask

	initial begin
		logic [22:0] radii[6];
		arst_n = 0; start = 0; cfg_we = 0; cfg_wdata = '0;
		lat_a = '0; lon_a = '0; lat_b = '0; lon_b = '0;
		no_gaps = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes, same point, antipodes, poles, wrapping.
		send_pair(0, 0, 0, 0);
		send_pair(900000000, 0, -900000000, 0);
		send_pair(0, 0, 0, 1800000000);
		send_pair(0, -1800000000, 0, 1800000000);
		send_pair(-900000000, -1800000000, 900000000, 1800000000);
		send_pair(900000000, 1234567, 900000000, -7654321);
		send_pair(0, 900000000, 0, -900000000);
		send_pair(31'sh3FFFFFFF, 32'sh7FFFFFFF, 31'sh40000000, 32'sh80000000);
		send_pair(31'sh40000000, 32'sh80000000, 31'sh3FFFFFFF, 32'sh7FFFFFFF);
		send_pair(-1, -1, -1, -1);
		send_pair(515000000, -1270000, 515000001, -1270000);
		send_pair(407000000, -740000000, -338000000, 1512000000);
		send_pair(1000000000, 0, -1000000000, 0);
		send_pair(0, 32'sh7FFFFFFF, 0, 32'sh80000000);
		send_pair(-450000000, 1799999999, 450000000, -1799999999);

		// Radius settings: reset value first, then extremes and random ones.
		radii = '{23'd6300000, 23'd6400000, 23'd0, 23'h7FFFFF, 23'd1,
			23'(6300000 + $urandom_range(0, 100000))};
		for (int p = 0; p <= 6; p++) begin
			if (p > 0) set_radius(radii[p - 1]);
			no_gaps = (p == 2);
			for (int n = 0; n < RANDOM_PER_PHASE - 15 * (p == 0 ? 1 : 0); n++) begin
				if (n == RANDOM_PER_PHASE / 2) no_gaps = !no_gaps;
				send_random_pair();
			end
		end
		set_radius(23'd6371000);
		for (int n = 0; n < 15; n++) send_random_pair();

		@(negedge clk);
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (gcd_pkg::TOP_LATENCY + 10) @(negedge clk);

		$display("Sent %0d position pairs, checked %0d distances", beats_in, beats_out);
		$display("Radius settings: reset, 6300000, 6400000, 0, max, 1, random in range");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/gcd_pkg.sv
rtl/gcd_sincos.sv
rtl/gcd_acos.sv
rtl/great_circle_distance_unit.sv
rtl/gcd_checker.sv
bench/great_circle_distance_checker.sv
bench/great_circle_distance_unit_test.sv
